FILE: hdl/aic_pkg.sv
// Shared types and constants for the actuated intersection controller.
`default_nettype none

package aic_pkg;

  // Event codes carried in the action field
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_CAR    = 2'd1,
    ACT_BUTTON = 2'd2
  } action_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WALKING_DELAY = 3'd0,
    CFG_AMBER_DELAY   = 3'd1,
    CFG_MIN_GREEN     = 3'd2,
    CFG_RED_WAIT_MAX  = 3'd3,
    CFG_PED_WAIT_MAX  = 3'd4,
    CFG_IDLE_GREEN    = 3'd5,
    CFG_BLINK_PERIOD  = 3'd6
  } cfg_index_t;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int AMBER_WIDTH     = 12;

  // Time advance of one timer tick
  localparam int TICK_STEP = 10;

  // Register reset values
  localparam logic [15:0] RST_WALKING_DELAY = 16'd500;
  localparam logic [11:0] RST_AMBER_DELAY   = 12'd100;
  localparam logic [15:0] RST_MIN_GREEN     = 16'd300;
  localparam logic [15:0] RST_RED_WAIT_MAX  = 16'd2000;
  localparam logic [15:0] RST_PED_WAIT_MAX  = 16'd1000;
  localparam logic [15:0] RST_IDLE_GREEN    = 16'd1500;
  localparam logic [15:0] RST_BLINK_PERIOD  = 16'd40;

  // Direction codes
  localparam logic DIR_NS = 1'b0;
  localparam logic DIR_EW = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] source;
  } in_t;

  typedef struct packed {
    logic       green_dir;
    logic       switched;
    logic [3:0] cars_present;
    logic       ns_ped_lamp;
    logic       ew_ped_lamp;
    logic       ns_ped_pending;
    logic       ew_ped_pending;
  } out_t;

  typedef struct packed {
    logic [15:0] walking_delay;
    logic [11:0] amber_delay;
    logic [15:0] min_green;
    logic [15:0] red_wait_max;
    logic [15:0] ped_wait_max;
    logic [15:0] idle_green;
    logic [15:0] blink_period;
  } cfg_t;

  // Control part of the controller state (timestamps travel separately)
  typedef struct packed {
    logic       green;
    logic [3:0] car_bits;
    logic       red_valid;
    logic       ped_valid;
    logic [1:0] ped_requests;
    logic [1:0] ped_lamps;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/aic_core.sv
// Event update and switching rules for one request, purely combinational.
`default_nettype none

module aic_core #(
  parameter int TIME_WIDTH = 16
) (
  input  aic_pkg::in_t             req,
  input  aic_pkg::cfg_t            cfg,
  input  aic_pkg::ctrl_t           ctrl,
  input  logic [TIME_WIDTH-1:0]    elapsed,
  input  logic [TIME_WIDTH-1:0]    red_start,
  input  logic [TIME_WIDTH-1:0]    ped_start,
  input  logic [TIME_WIDTH-1:0]    blink_start,
  output aic_pkg::ctrl_t           ctrl_next,
  output logic [TIME_WIDTH-1:0]    elapsed_next,
  output logic [TIME_WIDTH-1:0]    red_start_next,
  output logic [TIME_WIDTH-1:0]    ped_start_next,
  output logic [TIME_WIDTH-1:0]    blink_start_next,
  output aic_pkg::out_t            result
);
  import aic_pkg::*;

  // Signed width for the rule arithmetic: time and 16-bit limits plus margin
  localparam int BASE_W = (TIME_WIDTH > CFG_DATA_WIDTH) ? TIME_WIDTH : CFG_DATA_WIDTH;
  localparam int CW     = BASE_W + 3;

  ctrl_t                  c;
  logic [TIME_WIDTH-1:0]  e;
  logic [TIME_WIDTH-1:0]  rs;
  logic [TIME_WIDTH-1:0]  ps;
  logic [TIME_WIDTH-1:0]  bs;
  logic [TIME_WIDTH:0]    tick_sum;
  logic signed [CW-1:0]   e_s;
  logic signed [CW-1:0]   amb_s;
  logic signed [CW-1:0]   amb2_s;
  logic signed [CW-1:0]   walk_lim_s;
  logic signed [CW-1:0]   blink_diff;
  logic                   due;
  logic                   red_when;
  logic                   ns_cars;
  logic                   ew_cars;
  logic                   fire;

  always_comb begin
    c  = ctrl;
    e  = elapsed;
    rs = red_start;
    ps = ped_start;
    bs = blink_start;

    tick_sum   = {1'b0, elapsed} + (TIME_WIDTH+1)'(TICK_STEP);
    blink_diff = '0;
    due        = 1'b0;
    red_when   = 1'b0;

    // Apply the event
    if (req.action == ACT_TICK) begin
      e = tick_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : tick_sum[TIME_WIDTH-1:0];
      blink_diff = $signed(CW'(e) - CW'(blink_start));
      due = blink_diff >= $signed(CW'(cfg.blink_period));
      if (ctrl.ped_requests[0] && due) begin
        bs = e;
        c.ped_lamps[0] = ~c.ped_lamps[0];
      end
      if (ctrl.ped_requests[1] && due) begin
        bs = e;
        c.ped_lamps[1] = ~c.ped_lamps[1];
      end
    end else if (req.action == ACT_CAR) begin
      // south and north cars wait at red while east-west is green
      red_when = ~req.source[0];
      if (ctrl.green == red_when && (!ctrl.red_valid || red_start > elapsed)) begin
        rs = elapsed;
        c.red_valid = 1'b1;
      end
      c.car_bits[req.source] = ~c.car_bits[req.source];
    end else if (req.action == ACT_BUTTON) begin
      if (!req.source[1] && ctrl.green == req.source[0] &&
          (!ctrl.ped_valid || ped_start > elapsed)) begin
        c.ped_requests[req.source[0]] = 1'b1;
        ps = elapsed;
        c.ped_valid = 1'b1;
        bs = elapsed;
        c.ped_lamps[req.source[0]] = ~c.ped_lamps[req.source[0]];
      end
    end

    // Switching rules on the updated state; the walk limit may go negative
    e_s        = $signed(CW'(e));
    amb_s      = $signed(CW'(cfg.amber_delay));
    amb2_s     = amb_s + amb_s;
    walk_lim_s = $signed(CW'(cfg.walking_delay)) - amb2_s;
    ns_cars    = c.car_bits[0] | c.car_bits[2];
    ew_cars    = c.car_bits[1] | c.car_bits[3];
    fire       = 1'b0;
    if ((e_s > walk_lim_s) && (e_s > $signed(CW'(cfg.min_green)))) begin
      priority if (ew_cars && !ns_cars && c.green == DIR_NS) begin
        fire = 1'b1;
      end else if (ns_cars && !ew_cars && c.green == DIR_EW) begin
        fire = 1'b1;
      end else if (c.red_valid &&
                   (e_s - $signed(CW'(rs)) + amb2_s >= $signed(CW'(cfg.red_wait_max)))) begin
        fire = 1'b1;
      end else if (c.ped_valid &&
                   (e_s - $signed(CW'(ps)) + amb_s >= $signed(CW'(cfg.ped_wait_max)))) begin
        fire = 1'b1;
      end else if ((e_s + amb2_s >= $signed(CW'(cfg.idle_green))) &&
                   c.car_bits == 4'd0) begin
        fire = 1'b1;
      end else begin
        fire = 1'b0;
      end
    end

    // Direction change
    if (fire) begin
      if ((c.green == DIR_EW && ew_cars) || (c.green == DIR_NS && ns_cars)) begin
        rs = '0;
        c.red_valid = 1'b1;
      end else begin
        c.red_valid = 1'b0;
      end
      c.ped_valid = 1'b0;
      c.ped_lamps[c.green]    = 1'b0;
      c.ped_requests[c.green] = 1'b0;
      c.green = ~c.green;
      bs = '0;
      e  = '0;
    end

    ctrl_next        = c;
    elapsed_next     = e;
    red_start_next   = rs;
    ped_start_next   = ps;
    blink_start_next = bs;

    result.green_dir      = c.green;
    result.switched       = fire;
    result.cars_present   = c.car_bits;
    result.ns_ped_lamp    = c.ped_lamps[0];
    result.ew_ped_lamp    = c.ped_lamps[1];
    result.ns_ped_pending = c.ped_requests[0];
    result.ew_ped_pending = c.ped_requests[1];
  end

endmodule

`default_nettype wire

FILE: hdl/actuated_intersection_controller_unit.sv
// Top level of the actuated intersection controller: registers, handshake, configuration.
// A request goes from the input register through the core into the result register (out_data).
// Throughput: one request per cycle while out_ready does not stall; the state update of each
// request is a single combinational pass between the input register and the result register.
// Reset (rst, synchronous, active high) empties both stages, loads the default
// configuration and clears the controller state.
`default_nettype none

module actuated_intersection_controller_unit #(
  parameter int TIME_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  aic_pkg::in_t                         in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output aic_pkg::out_t                        out_data,
  input  logic                                 cfg_we,
  input  logic [aic_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [aic_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import aic_pkg::*;

  in_t                    req;
  logic                   req_valid;
  logic                   advance;
  cfg_t                   cfg;
  ctrl_t                  ctrl;
  ctrl_t                  ctrl_next;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic [TIME_WIDTH-1:0]  elapsed_next;
  logic [TIME_WIDTH-1:0]  red_start;
  logic [TIME_WIDTH-1:0]  red_start_next;
  logic [TIME_WIDTH-1:0]  ped_start;
  logic [TIME_WIDTH-1:0]  ped_start_next;
  logic [TIME_WIDTH-1:0]  blink_start;
  logic [TIME_WIDTH-1:0]  blink_start_next;
  out_t                   result;

  // Handshake: the input stage moves on whenever the result slot is free or draining
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.walking_delay <= RST_WALKING_DELAY;
      cfg.amber_delay   <= RST_AMBER_DELAY;
      cfg.min_green     <= RST_MIN_GREEN;
      cfg.red_wait_max  <= RST_RED_WAIT_MAX;
      cfg.ped_wait_max  <= RST_PED_WAIT_MAX;
      cfg.idle_green    <= RST_IDLE_GREEN;
      cfg.blink_period  <= RST_BLINK_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WALKING_DELAY: cfg.walking_delay <= cfg_data;
        CFG_AMBER_DELAY:   cfg.amber_delay   <= cfg_data[AMBER_WIDTH-1:0];
        CFG_MIN_GREEN:     cfg.min_green     <= cfg_data;
        CFG_RED_WAIT_MAX:  cfg.red_wait_max  <= cfg_data;
        CFG_PED_WAIT_MAX:  cfg.ped_wait_max  <= cfg_data;
        CFG_IDLE_GREEN:    cfg.idle_green    <= cfg_data;
        CFG_BLINK_PERIOD:  cfg.blink_period  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
    if (in_ready) begin
      req <= in_data;
    end
  end

  // Event and rule logic
  aic_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .req              (req),
    .cfg              (cfg),
    .ctrl             (ctrl),
    .elapsed          (elapsed),
    .red_start        (red_start),
    .ped_start        (ped_start),
    .blink_start      (blink_start),
    .ctrl_next        (ctrl_next),
    .elapsed_next     (elapsed_next),
    .red_start_next   (red_start_next),
    .ped_start_next   (ped_start_next),
    .blink_start_next (blink_start_next),
    .result           (result)
  );

  // Controller state, updated as each request leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl        <= '0;
      elapsed     <= '0;
      red_start   <= '0;
      ped_start   <= '0;
      blink_start <= '0;
    end else if (advance) begin
      ctrl        <= ctrl_next;
      elapsed     <= elapsed_next;
      red_start   <= red_start_next;
      ped_start   <= ped_start_next;
      blink_start <= blink_start_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire
